### hw/rtl/ytab_pkg.sv
package ytab_pkg;

    localparam int SIZE_DEF       = 8;
    localparam int VALUE_BITS_DEF = 8;

    // Field widths of the stream payload
    localparam int POS_W  = 3;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0]
    {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_RUN,
        S_OUT
    } fsm_t;

endpackage

### hw/rtl/ytab_row.sv
// One tableau row: holds SIZE cells and performs one bump step when enabled.
module ytab_row
    import ytab_pkg::*;
#(
    parameter int SIZE       = SIZE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,     // this row is visited now
    input  cmd_t                          cmd,
    input  logic [VALUE_BITS-1:0]         carry_in,
    input  logic                          clear_en,    // empty cell clear_col
    input  logic [$clog2(SIZE)-1:0]       clear_col,
    output logic [VALUE_BITS-1:0]         carry_out,
    output logic                          hit,         // insert found a cell / delete swapped
    output logic                          hit_empty,   // insert hit an empty cell
    output logic [$clog2(SIZE)-1:0]       hit_col,
    output logic [VALUE_BITS-1:0]         cell_rd,
    output logic                          cell_occ     // occupancy of cell clear_col
)
;
    localparam int CW = $clog2(SIZE);

    logic [VALUE_BITS-1:0] val_reg [SIZE];
    logic [SIZE-1:0]       occ_reg;

    logic [SIZE-1:0]       lead;    // cell is within leading occupied run
    logic [SIZE-1:0]       ins_m;
    logic [SIZE-1:0]       del_m;

    // Build per-cell match flags
    always_comb
    begin
        logic run;
        run = 1'b1;
        for (int c = 0; c < SIZE; c++)
        begin
            ins_m[c] = !occ_reg[c] || (val_reg[c] > carry_in);
            run      = run && occ_reg[c];
            lead[c]  = run;
            del_m[c] = lead[c] && (val_reg[c] < carry_in);
        end
    end

    // Pick leftmost insert match or rightmost delete match
    always_comb
    begin
        hit     = 1'b0;
        hit_col = '0;
        if (cmd == CMD_INSERT)
        begin
            for (int c = SIZE - 1; c >= 0; c--)
            begin
                if (ins_m[c])
                begin
                    hit     = 1'b1;
                    hit_col = CW'(c);
                end
            end
        end
        else
        begin
            for (int c = 0; c < SIZE; c++)
            begin
                if (del_m[c])
                begin
                    hit     = 1'b1;
                    hit_col = CW'(c);
                end
            end
        end
        hit_empty = !occ_reg[hit_col];
        cell_rd   = val_reg[clear_col];
        cell_occ  = occ_reg[clear_col];
        carry_out = hit ? val_reg[hit_col] : carry_in;
    end

    // Occupancy bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (clear_en)
        begin
            occ_reg[clear_col] <= 1'b0;
        end
        else if (step_en && hit && cmd == CMD_INSERT && hit_empty)
        begin
            occ_reg[hit_col] <= 1'b1;
        end
    end

    // Cell values
    always_ff @(posedge clk)
    begin
        if (step_en && hit && !clear_en)
        begin
            val_reg[hit_col] <= carry_in;
        end
    end

endmodule

### hw/rtl/young_tableau_row_insert_delete.sv
// Young tableau with row insertion (bumping) and deletion (reverse bumping).
// Input stream s_axis: tdata {cell_col, cell_row, value}, tuser = command
// (0 insert value, 1 delete cell at cell_row/cell_col). One result per item
// on m_axis: tdata {ejected_value, placed_col, placed_row, status}.
// Storage is a chain of row cells; a sequencer visits one row per cycle.
// Insert walks down from row 0 and stops at the first row with an empty
// hit or at overflow. Delete clears the cell then walks up from cell_row-1
// to row 0 (no walk when cell_row is 0). The result is then loaded into the
// result register; one item at a time. Reset empties the tableau at once
// (occupancy bits cleared); no pass is needed. The result waits in an
// output register until m_axis_tready; no new item is taken until it leaves.
module young_tableau_row_insert_delete
    import ytab_pkg::*;
#(
    parameter int SIZE       = SIZE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value[7:0], cell_row[10:8], cell_col[13:11]
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[1:0], placed_row[4:2], placed_col[7:5],
                                        // ejected_value[15:8]
);
    localparam int CW = $clog2(SIZE);

    fsm_t                   st_reg, st_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CW-1:0]          row_reg, row_next;
    logic [VALUE_BITS-1:0]  carry_reg, carry_next;
    logic [15:0]            out_reg, out_next;

    logic [VALUE_BITS-1:0]  r_carry [SIZE];
    logic [SIZE-1:0]        r_hit, r_hemp, r_step, r_clr, r_occ;
    logic [CW-1:0]          r_col [SIZE];
    logic [VALUE_BITS-1:0]  r_rd [SIZE];

    logic [VALUE_BITS-1:0]  in_val;
    logic [POS_W-1:0]       in_row, in_col;
    logic                   in_rng;
    logic                   acc;

    logic                   del_occ;
    logic [VALUE_BITS-1:0]  del_val;

    logic [VALUE_BITS-1:0]  cur_carry;
    logic                   cur_hit, cur_hemp;
    logic [CW-1:0]          cur_col;

    assign in_val = VALUE_BITS'(s_axis_tdata[VAL_W-1:0] & VAL_W'((1 << VALUE_BITS) - 1));
    assign in_row = s_axis_tdata[10:8];
    assign in_col = s_axis_tdata[13:11];
    assign in_rng = (32'(in_row) < SIZE) && (32'(in_col) < SIZE);
    assign acc    = s_axis_tvalid && s_axis_tready;

    // Row chain
    genvar g;
    generate
        for (g = 0; g < SIZE; g++)
        begin : g_row
            assign r_step[g] = (st_reg == S_RUN) && (row_reg == CW'(g));
            assign r_clr[g]  = acc && s_axis_tuser && in_rng
                               && (CW'(in_row) == CW'(g));
            ytab_row #(.SIZE(SIZE), .VALUE_BITS(VALUE_BITS)) u_row
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .step_en   (r_step[g]),
                .cmd       (st_reg == S_RUN ? cmd_reg : cmd_t'(s_axis_tuser)),
                .carry_in  (carry_reg),
                .clear_en  (r_clr[g]),
                .clear_col (CW'(in_col)),
                .carry_out (r_carry[g]),
                .hit       (r_hit[g]),
                .hit_empty (r_hemp[g]),
                .hit_col   (r_col[g]),
                .cell_rd   (r_rd[g]),
                .cell_occ  (r_occ[g])
            );
        end
    endgenerate

    // Occupancy of the addressed delete cell, read from the row chain
    always_comb
    begin
        del_occ = 1'b0;
        del_val = '0;
        for (int r = 0; r < SIZE; r++)
        begin
            if (CW'(in_row) == CW'(r))
            begin
                del_occ = r_occ[r];
                del_val = r_rd[r];
            end
        end
    end

    assign cur_carry = r_carry[row_reg];
    assign cur_hit   = r_hit[row_reg];
    assign cur_hemp  = r_hemp[row_reg];
    assign cur_col   = r_col[row_reg];

    // Sequencer next state
    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        row_next   = row_reg;
        carry_next = carry_reg;
        out_next   = out_reg;
        s_axis_tready = (st_reg == S_IDLE);
        m_axis_tvalid = (st_reg == S_OUT);
        case (st_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next = cmd_t'(s_axis_tuser);
                    out_next = '0;
                    if (!s_axis_tuser)
                    begin
                        carry_next = in_val;
                        row_next   = '0;
                        st_next    = S_RUN;
                    end
                    else if (!in_rng || !del_occ)
                    begin
                        out_next[1:0] = ST_EMPTY;
                        st_next       = S_OUT;
                    end
                    else if (in_row == '0)
                    begin
                        out_next[15:8] = VAL_W'(del_val);
                        st_next        = S_OUT;
                    end
                    else
                    begin
                        carry_next = del_val;
                        row_next   = CW'(in_row) - 1'b1;
                        st_next    = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                carry_next = cur_carry;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!cur_hit)
                    begin
                        out_next[1:0] = ST_OVERFLOW;
                        st_next       = S_OUT;
                    end
                    else if (cur_hemp)
                    begin
                        out_next[4:2] = POS_W'(row_reg);
                        out_next[7:5] = POS_W'(cur_col);
                        st_next       = S_OUT;
                    end
                    else if (32'(row_reg) == SIZE - 1)
                    begin
                        out_next[1:0] = ST_OVERFLOW;
                        st_next       = S_OUT;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    if (row_reg == '0)
                    begin
                        out_next[15:8] = VAL_W'(cur_carry);
                        st_next        = S_OUT;
                    end
                    else
                    begin
                        row_next = row_reg - 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        row_reg   <= row_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

    assign m_axis_tdata = out_reg;

endmodule

### hw/rtl/ytab_checker.sv
// Port-level checks for the tableau block.
module ytab_checker
    import ytab_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // One item at a time: no intake while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Status code in range
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_DONE || m_axis_tdata[1:0] == ST_OVERFLOW
                           || m_axis_tdata[1:0] == ST_EMPTY))
        else $error("bad status");

    // Placement fields only on a done insert
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE) |-> m_axis_tdata[15:2] == 14'd0)
        else $error("fields set on failure");

    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
endmodule

bind young_tableau_row_insert_delete ytab_checker u_ytab_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
